@@ sv/per_client_request_limiter_assert.svh @@
// Assertion helpers for the limiter top level.
`ifndef PER_CLIENT_REQUEST_LIMITER_ASSERT_SVH
`define PER_CLIENT_REQUEST_LIMITER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PLC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("limiter assertion failed");

// Next-cycle implication, checked outside reset.
`define PLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("limiter assertion failed");

`endif

@@ sv/plc_pkg.sv @@
package plc_pkg;

    localparam int IP_W       = 32;
    localparam int PORT_W     = 16;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 8;
    localparam int SLOT_W     = 7;
    localparam int VERDICT_W  = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_BUSY   = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_LIMIT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT    = 8'd1;

    localparam logic [COUNT_W-1:0] RESET_REQUEST_LIMIT = 8'd10;
    localparam logic [TIME_W-1:0]  RESET_IDLE_LIMIT    = 32'd600;

    typedef struct packed {
        logic [IP_W-1:0]    ip;
        logic [PORT_W-1:0]  port;
        logic [TIME_W-1:0]  last_seen;
        logic [COUNT_W-1:0] count;
    } entry_t;

endpackage

@@ sv/plc_if.sv @@
interface plc_req_if;
    logic                          valid;
    logic                          ready;
    logic [plc_pkg::IP_W-1:0]      src_ip;
    logic [plc_pkg::PORT_W-1:0]    src_port;
    logic [plc_pkg::TIME_W-1:0]    now_seconds;

    modport source (output valid, output src_ip, output src_port, output now_seconds,
                    input ready);
    modport sink   (input valid, input src_ip, input src_port, input now_seconds,
                    output ready);
endinterface

interface plc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [plc_pkg::VERDICT_W-1:0]  verdict;
    logic [plc_pkg::SLOT_W-1:0]     slot;
    logic [plc_pkg::COUNT_W-1:0]    count_after;

    modport source (output valid, output verdict, output slot, output count_after,
                    input ready);
    modport sink   (input valid, input verdict, input slot, input count_after,
                    output ready);
endinterface

interface plc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [plc_pkg::CFG_IDX_W-1:0]   index;
    logic [plc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/plc_cell.sv @@
module plc_cell
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  plc_pkg::entry_t  entry_in,
    output plc_pkg::entry_t  entry_out
);

    plc_pkg::entry_t entry_reg;
    plc_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = shift ? entry_in : entry_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry_out = entry_reg;

endmodule

@@ sv/plc_ctrl.sv @@
module plc_ctrl
#(
    parameter int TABLE_DEPTH = 128,
    parameter int IDX_W       = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    plc_req_if.sink          req,
    plc_rsp_if.source        rsp,
    plc_cfg_if.sink          cfg,
    input  plc_pkg::entry_t  head,
    output logic             shift,
    output plc_pkg::entry_t  feedback
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             match_found_reg, match_found_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             claim_reg, claim_next;
    logic [IDX_W-1:0] target_reg, target_next;

    logic [plc_pkg::IP_W-1:0]   req_ip_reg;
    logic [plc_pkg::PORT_W-1:0] req_port_reg;
    logic [plc_pkg::TIME_W-1:0] req_now_reg;

    logic [plc_pkg::COUNT_W-1:0] request_limit_reg;
    logic [plc_pkg::TIME_W-1:0]  idle_limit_reg;

    logic [plc_pkg::VERDICT_W-1:0] res_verdict_reg, res_verdict_next;
    logic [IDX_W-1:0]              res_idx_reg, res_idx_next;
    logic [plc_pkg::COUNT_W-1:0]   res_count_reg, res_count_next;

    logic                          out_valid_reg, out_valid_next;
    logic [plc_pkg::VERDICT_W-1:0] out_verdict_reg;
    logic [plc_pkg::SLOT_W-1:0]    out_slot_reg;
    logic [plc_pkg::COUNT_W-1:0]   out_count_reg;
    logic                          out_load;

    logic                        head_match;
    logic                        head_free;
    plc_pkg::entry_t             base;
    logic [plc_pkg::TIME_W-1:0]  elapsed;
    logic [plc_pkg::COUNT_W-1:0] cnt;
    logic [plc_pkg::COUNT_W-1:0] cnt_inc;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign head_match = (head.ip == req_ip_reg) && (head.port == req_port_reg);
    assign head_free  = (head.count == '0);

    always_comb
    begin
        if (claim_reg)
        begin
            base.ip        = req_ip_reg;
            base.port      = req_port_reg;
            base.last_seen = req_now_reg;
            base.count     = '0;
        end
        else
        begin
            base = head;
        end
        elapsed = req_now_reg - base.last_seen;
        cnt     = (elapsed > idle_limit_reg) ? '0 : base.count;
        cnt_inc = cnt + 1'b1;
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        claim_next       = claim_reg;
        target_next      = target_reg;
        res_verdict_next = res_verdict_reg;
        res_idx_next     = res_idx_reg;
        res_count_next   = res_count_reg;
        shift            = 1'b0;
        feedback         = head;
        out_load         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next       = ST_SCAN;
                    idx_next         = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                end
            end
            ST_SCAN:
            begin
                shift = 1'b1;
                if (head_match && !match_found_reg)
                begin
                    match_found_next = 1'b1;
                    match_idx_next   = idx_reg;
                end
                if (head_free && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (idx_reg == IDX_LAST)
                begin
                    idx_next = '0;
                    if (match_found_next)
                    begin
                        state_next  = ST_APPLY;
                        claim_next  = 1'b0;
                        target_next = match_idx_next;
                    end
                    else if (free_found_next)
                    begin
                        state_next  = ST_APPLY;
                        claim_next  = 1'b1;
                        target_next = free_idx_next;
                    end
                    else
                    begin
                        state_next       = ST_DONE;
                        res_verdict_next = plc_pkg::VERDICT_BUSY;
                        res_idx_next     = '0;
                        res_count_next   = '0;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_APPLY:
            begin
                shift = 1'b1;
                if (idx_reg == target_reg)
                begin
                    res_idx_next = idx_reg;
                    feedback.ip   = base.ip;
                    feedback.port = base.port;
                    if (cnt >= request_limit_reg)
                    begin
                        feedback.last_seen = base.last_seen;
                        feedback.count     = cnt;
                        res_verdict_next   = plc_pkg::VERDICT_LIMIT;
                        res_count_next     = cnt;
                    end
                    else
                    begin
                        feedback.last_seen = req_now_reg;
                        feedback.count     = cnt_inc;
                        res_verdict_next   = plc_pkg::VERDICT_ACCEPT;
                        res_count_next     = cnt_inc;
                    end
                end
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            idx_reg           <= '0;
            match_found_reg   <= 1'b0;
            free_found_reg    <= 1'b0;
            claim_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
            request_limit_reg <= plc_pkg::RESET_REQUEST_LIMIT;
            idle_limit_reg    <= plc_pkg::RESET_IDLE_LIMIT;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            claim_reg       <= claim_next;
            out_valid_reg   <= out_valid_next;
            if (cfg.valid)
            begin
                if (cfg.index == plc_pkg::REG_REQUEST_LIMIT)
                begin
                    request_limit_reg <= cfg.data[plc_pkg::COUNT_W-1:0];
                end
                else if (cfg.index == plc_pkg::REG_IDLE_LIMIT)
                begin
                    idle_limit_reg <= cfg.data[plc_pkg::TIME_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg   <= match_idx_next;
        free_idx_reg    <= free_idx_next;
        target_reg      <= target_next;
        res_verdict_reg <= res_verdict_next;
        res_idx_reg     <= res_idx_next;
        res_count_reg   <= res_count_next;
        if (req.valid && req.ready)
        begin
            req_ip_reg   <= req.src_ip;
            req_port_reg <= req.src_port;
            req_now_reg  <= req.now_seconds;
        end
        if (out_load)
        begin
            out_verdict_reg <= res_verdict_reg;
            out_slot_reg    <= plc_pkg::SLOT_W'(res_idx_reg);
            out_count_reg   <= res_count_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.verdict     = out_verdict_reg;
    assign rsp.slot        = out_slot_reg;
    assign rsp.count_after = out_count_reg;

endmodule

@@ sv/per_client_request_limiter.sv @@
// Per-client request limiter.
// req (sink): one beat per request, src_ip, src_port and now_seconds.
// rsp (source): one beat per request, verdict (accept, busy, limit), slot and
//   count_after; slot and count_after are zero on busy.
// cfg (sink): register writes, index 0 request_limit, index 1 idle_limit;
//   always ready, other indexes are dropped. Write only while idle.
// The client table is a ring of TABLE_DEPTH cells that rotates one entry per
// cycle, only while a request is in progress, past a single compare/update
// point at its head. After a request beat, one full rotation finds the match
// and the first free entry; a second rotation writes the chosen entry back.
// When neither is found the verdict is busy and the second rotation is skipped.
// The response is then loaded into the output register, and req becomes ready
// again in the same cycle as rsp.valid rises.
// req is not ready until the response is in the output register.
// Reset clears every cell at once and loads the register defaults (10, 600).
// When rsp stalls, the finished result waits in the controller and the next
// request is taken only after it moves to the output register.
`include "per_client_request_limiter_assert.svh"

module per_client_request_limiter
#(
    parameter int TABLE_DEPTH = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    plc_req_if.sink    req,
    plc_rsp_if.source  rsp,
    plc_cfg_if.sink    cfg
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    plc_pkg::entry_t chain_w [TABLE_DEPTH];
    plc_pkg::entry_t feedback_w;
    logic            shift_w;

    plc_ctrl
    #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    )
    u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cfg      (cfg),
        .head     (chain_w[0]),
        .shift    (shift_w),
        .feedback (feedback_w)
    );

    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        if (k == TABLE_DEPTH - 1)
        begin : g_tail
            plc_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (shift_w),
                .entry_in  (feedback_w),
                .entry_out (chain_w[k])
            );
        end
        else
        begin : g_body
            plc_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (shift_w),
                .entry_in  (chain_w[k+1]),
                .entry_out (chain_w[k])
            );
        end
    end

    `PLC_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req.valid && req.ready, !req.ready)
    `PLC_ASSERT_SAME(a_busy_fields, clk, rst_n,
        rsp.valid && (rsp.verdict == plc_pkg::VERDICT_BUSY),
        (rsp.slot == '0) && (rsp.count_after == '0))
    `PLC_ASSERT_SAME(a_accept_count, clk, rst_n,
        rsp.valid && (rsp.verdict == plc_pkg::VERDICT_ACCEPT), rsp.count_after != '0)
    `PLC_ASSERT_SAME(a_verdict_code, clk, rst_n, rsp.valid,
        (rsp.verdict == plc_pkg::VERDICT_ACCEPT) || (rsp.verdict == plc_pkg::VERDICT_BUSY)
        || (rsp.verdict == plc_pkg::VERDICT_LIMIT))

endmodule
